>>> src/pdrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrt_pkg: shared types and constants for the prescaled dual reload timer
// Request/response words, operation codes, register map, control bits.
// ----------------------------------------------------------------------------
package pdrt_pkg;

   // operation codes
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // register map
   localparam logic [3:0] REG_CNT1     = 4'd0;
   localparam logic [3:0] REG_LOAD1    = 4'd1;
   localparam logic [3:0] REG_CTRL1    = 4'd2;
   localparam logic [3:0] REG_WDOG     = 4'd3;
   localparam logic [3:0] REG_CNT2     = 4'd4;
   localparam logic [3:0] REG_LOAD2    = 4'd5;
   localparam logic [3:0] REG_CTRL2    = 4'd6;
   localparam logic [3:0] REG_SPARE    = 4'd7;
   localparam logic [3:0] REG_PRESCNT  = 4'd8;
   localparam logic [3:0] REG_PRESLOAD = 4'd9;

   localparam int DATA_BITS  = 24;   // width of write_data
   localparam int COUNT_BITS = 32;   // counters and read data

   localparam logic [COUNT_BITS-1:0] ALL_ONES = 32'hffff_ffff;

   // control register bits
   localparam int CTRL_ENABLE_BIT = 0;
   localparam int CTRL_RELOAD_BIT = 1;
   localparam logic [DATA_BITS-1:0] CTRL_KEEP = 24'h00_0006;

   typedef struct packed {
      logic [1:0]           operation;
      logic [3:0]           reg_index;
      logic [DATA_BITS-1:0] write_data;
   } req_word_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] read_data;
      logic                  bad_index;
      logic                  first_irq;
      logic                  second_irq;
   } rsp_word_type;

endpackage

>>> src/pdrt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrt_core: timer register file and single-pass update logic
// Holds prescaler and both timers; computes one response per executed word.
// ----------------------------------------------------------------------------
module pdrt_core #(
   parameter int WRITE_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  pdrt_pkg::req_word_type item,
   output pdrt_pkg::rsp_word_type result
);

   // bits actually kept on a write
   localparam int KeepBits = (WRITE_BITS < pdrt_pkg::DATA_BITS) ?
                             WRITE_BITS : pdrt_pkg::DATA_BITS;
   localparam int PadBits  = pdrt_pkg::COUNT_BITS - KeepBits;

   logic [pdrt_pkg::COUNT_BITS-1:0] pres_cnt_ff, pres_cnt_in;
   logic [KeepBits-1:0]             pres_load_ff, pres_load_in;
   logic [pdrt_pkg::COUNT_BITS-1:0] cnt1_ff, cnt1_in, cnt2_ff, cnt2_in;
   logic [KeepBits-1:0]             load1_ff, load1_in, load2_ff, load2_in;
   logic [KeepBits-1:0]             ctrl1_ff, ctrl1_in, ctrl2_ff, ctrl2_in;
   logic [KeepBits-1:0]             wdog_ff, wdog_in, spare_ff, spare_in;

   logic [KeepBits-1:0]             wdata;
   logic [pdrt_pkg::COUNT_BITS-1:0] wdata_ext;
   logic [pdrt_pkg::COUNT_BITS-1:0] t1_dec, t2_dec;
   logic                            wrap, t1_under, t2_under, is_bad;
   logic [pdrt_pkg::COUNT_BITS-1:0] rd_mux;

   assign wdata     = item.write_data[KeepBits-1:0];
   assign wdata_ext = {{PadBits{1'b0}}, wdata};

   // prescaler wraps when it leaves zero
   assign wrap   = (pres_cnt_ff == '0);
   assign t1_dec = ctrl1_ff[pdrt_pkg::CTRL_ENABLE_BIT] ? cnt1_ff - 32'd1 : cnt1_ff;
   assign t2_dec = ctrl2_ff[pdrt_pkg::CTRL_ENABLE_BIT] ? cnt2_ff - 32'd1 : cnt2_ff;
   assign t1_under = (t1_dec == pdrt_pkg::ALL_ONES);
   assign t2_under = (t2_dec == pdrt_pkg::ALL_ONES);

   // read mux and index check
   always_comb begin
      is_bad = 1'b0;
      rd_mux = '0;
      unique case (item.reg_index)
         pdrt_pkg::REG_CNT1:     rd_mux = cnt1_ff;
         pdrt_pkg::REG_LOAD1:    rd_mux = {{PadBits{1'b0}}, load1_ff};
         pdrt_pkg::REG_CTRL1:    rd_mux = {{PadBits{1'b0}}, ctrl1_ff};
         pdrt_pkg::REG_WDOG:     rd_mux = {{PadBits{1'b0}}, wdog_ff};
         pdrt_pkg::REG_CNT2:     rd_mux = cnt2_ff;
         pdrt_pkg::REG_LOAD2:    rd_mux = {{PadBits{1'b0}}, load2_ff};
         pdrt_pkg::REG_CTRL2:    rd_mux = {{PadBits{1'b0}}, ctrl2_ff};
         pdrt_pkg::REG_SPARE:    rd_mux = {{PadBits{1'b0}}, spare_ff};
         pdrt_pkg::REG_PRESCNT:  rd_mux = pres_cnt_ff;
         pdrt_pkg::REG_PRESLOAD: rd_mux = {{PadBits{1'b0}}, pres_load_ff};
         default:                is_bad = 1'b1;
      endcase
   end

   always_comb begin
      pres_cnt_in  = pres_cnt_ff;
      pres_load_in = pres_load_ff;
      cnt1_in      = cnt1_ff;
      load1_in     = load1_ff;
      ctrl1_in     = ctrl1_ff;
      cnt2_in      = cnt2_ff;
      load2_in     = load2_ff;
      ctrl2_in     = ctrl2_ff;
      wdog_in      = wdog_ff;
      spare_in     = spare_ff;
      result       = '0;

      if (go) begin
         unique case (item.operation)
            pdrt_pkg::OP_READ: begin
               result.bad_index = is_bad;
               result.read_data = rd_mux;
            end
            pdrt_pkg::OP_WRITE: begin
               result.bad_index = is_bad;
               unique case (item.reg_index)
                  pdrt_pkg::REG_CNT1:     cnt1_in      = wdata_ext;
                  pdrt_pkg::REG_LOAD1:    load1_in     = wdata;
                  pdrt_pkg::REG_CTRL1:    ctrl1_in     = wdata;
                  pdrt_pkg::REG_WDOG:     wdog_in      = wdata;
                  pdrt_pkg::REG_CNT2:     cnt2_in      = wdata_ext;
                  pdrt_pkg::REG_LOAD2:    load2_in     = wdata;
                  pdrt_pkg::REG_CTRL2:    ctrl2_in     = wdata;
                  pdrt_pkg::REG_SPARE:    spare_in     = wdata;
                  pdrt_pkg::REG_PRESCNT:  pres_cnt_in  = wdata_ext;
                  pdrt_pkg::REG_PRESLOAD: pres_load_in = wdata;
                  default: ;
               endcase
            end
            pdrt_pkg::OP_TICK: begin
               if (wrap) begin
                  pres_cnt_in = {{PadBits{1'b0}}, pres_load_ff};
                  result.first_irq  = t1_under;
                  result.second_irq = t2_under;
                  cnt1_in = t1_dec;
                  if (t1_under) begin
                     if (ctrl1_ff[pdrt_pkg::CTRL_RELOAD_BIT])
                        cnt1_in = {{PadBits{1'b0}}, load1_ff};
                     else
                        ctrl1_in = ctrl1_ff & pdrt_pkg::CTRL_KEEP[KeepBits-1:0];
                  end
                  cnt2_in = t2_dec;
                  if (t2_under) begin
                     if (ctrl2_ff[pdrt_pkg::CTRL_RELOAD_BIT])
                        cnt2_in = {{PadBits{1'b0}}, load2_ff};
                     else
                        ctrl2_in = ctrl2_ff & pdrt_pkg::CTRL_KEEP[KeepBits-1:0];
                  end
               end else begin
                  pres_cnt_in = pres_cnt_ff - 32'd1;
               end
            end
            default: ;   // unused code: no effect, zero response
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pres_cnt_ff  <= '0;
         pres_load_ff <= '0;
         cnt1_ff      <= '0;
         load1_ff     <= '0;
         ctrl1_ff     <= '0;
         cnt2_ff      <= '0;
         load2_ff     <= '0;
         ctrl2_ff     <= '0;
         wdog_ff      <= '0;
         spare_ff     <= '0;
      end else begin
         pres_cnt_ff  <= pres_cnt_in;
         pres_load_ff <= pres_load_in;
         cnt1_ff      <= cnt1_in;
         load1_ff     <= load1_in;
         ctrl1_ff     <= ctrl1_in;
         cnt2_ff      <= cnt2_in;
         load2_ff     <= load2_in;
         ctrl2_ff     <= ctrl2_in;
         wdog_ff      <= wdog_in;
         spare_ff     <= spare_in;
      end
   end

endmodule

>>> src/prescaled_dual_reload_timer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prescaled_dual_reload_timer_unit: prescaler plus two reloadable timers
// Register reads, register writes and tick words go in; one response each.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | word
//  --------+-------------------------+-------------------------------------------
//  req     | req_valid / req_ready   | req_word (operation, reg_index, write_data)
//  rsp     | rsp_valid / rsp_ready   | rsp_word (read_data, bad_index, irqs)
//
// Throughput: one word per clock, sustained while rsp_ready stays high.
// Path: the input register takes the word on the accepting edge, then the
//   timer update lands in the response register and rsp_valid rises.
// Reset: synchronous, active high; clears all timer registers and both
//   stage valids.
// Stalls: the response register holds while rsp_ready is low; the input
//   register still takes one more word, then req_ready drops.
// Words execute in order, so a tick sees every earlier write.
// ----------------------------------------------------------------------------
module prescaled_dual_reload_timer_unit #(
   parameter int WRITE_BITS = 24     // bits kept on a write, 8..32 (capped at 24)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pdrt_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pdrt_pkg::rsp_word_type rsp_word
);

   // input stage
   logic                   in_valid_ff, in_valid_in;
   pdrt_pkg::req_word_type in_word_ff, in_word_in;

   // response stage
   logic                   rsp_valid_ff, rsp_valid_in;
   pdrt_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                   req_fire;
   logic                   go;       // execute the held word this cycle
   pdrt_pkg::rsp_word_type result;

   // the held word executes whenever the response slot is free or draining
   assign go        = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || go;
   assign req_fire  = req_valid && req_ready;

   pdrt_core #(
      .WRITE_BITS (WRITE_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .go     (go),
      .item   (in_word_ff),
      .result (result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_word_in   = in_word_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      if (go)
         in_valid_in = 1'b0;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_word_in  = req_word;
      end

      if (rsp_ready)
         rsp_valid_in = 1'b0;
      if (go) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // interrupts only come from ticks
   a_irq_tick_only: assert property (@(posedge clock) disable iff (reset)
      go && in_word_ff.operation != pdrt_pkg::OP_TICK
      |=> !rsp_word.first_irq && !rsp_word.second_irq)
      else $error("timer irq on a non-tick word");

   // a bad index never returns data
   a_bad_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.bad_index |-> rsp_word.read_data == '0)
      else $error("read data with bad index");

   // an executed word always lands in the response register
   a_go_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      go |=> rsp_valid)
      else $error("executed word lost");

   // an accepted word is held in the input stage
   a_fire_fills_in: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> in_valid_ff)
      else $error("accepted word dropped");

endmodule
